// File: rtl/fsd_pkg.sv
`timescale 1ns / 1ps

package fsd_pkg;

    // character codes used by the flat scheme
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DOLLAR     = 8'h24;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;

    // prefix walk: positions 0..3 match the prefix, then the capital, then the body
    localparam logic [2:0] POS_CAPITAL = 3'd4;
    localparam logic [2:0] POS_BODY    = 3'd5;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // bytes held back for lookahead
    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_UNDER  = 2'd1,
        KIND_DOLLAR = 2'd2,
        KIND_DIGIT  = 2'd3
    } t_kind;

    // all results caused by one input byte, first byte in slot 0
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
        logic            not_flat;
        logic            last;
    } t_bundle;

    // expected prefix byte at each match position
    function automatic logic [7:0] prefix_char(input logic [1:0] p);
        logic [7:0] c;
        unique case (p)
            2'd0: c = 8'h63;
            2'd1: c = 8'h61;
            2'd2: c = 8'h6D;
            2'd3: c = 8'h6C;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/fsd_front.sv
`timescale 1ns / 1ps

module fsd_front
    import fsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_push,
    output t_bundle    o_bundle
);

    logic [2:0] r_pos;
    logic       r_rejected;
    t_kind      r_kind;
    logic [7:0] r_digit;

    logic [2:0] n_pos;
    logic       n_rejected;
    t_kind      n_kind;
    logic [7:0] n_digit;

    t_kind      fresh_kind;
    logic       byte_hex;
    logic       byte_upper;
    t_bundle    bun;

    // add one result byte, at most three per input beat
    function automatic t_bundle append(input t_bundle x, input logic [7:0] c);
        t_bundle y;
        y = x;
        if (x.count != 2'd3) begin
            y.bytes[x.count] = c;
            y.count          = x.count + 2'd1;
        end
        return y;
    endfunction

    // value of an ascii hex digit
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        if (c <= 8'h39) begin
            v = c[3:0];
        end else begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

    // classify the incoming byte
    always_comb begin
        byte_hex   = (i_byte >= 8'h30 && i_byte <= 8'h39) ||
                     (i_byte >= 8'h41 && i_byte <= 8'h46) ||
                     (i_byte >= 8'h61 && i_byte <= 8'h66);
        byte_upper = (i_byte >= CH_UPPER_A) && (i_byte <= CH_UPPER_Z);
        if (i_byte == CH_UNDERSCORE) begin
            fresh_kind = KIND_UNDER;
        end else if (i_byte == CH_DOLLAR) begin
            fresh_kind = KIND_DOLLAR;
        end else begin
            fresh_kind = KIND_NONE;
        end
    end

    // prefix match, body decode and end-of-symbol flush
    always_comb begin
        n_pos      = r_pos;
        n_rejected = r_rejected;
        n_kind     = r_kind;
        n_digit    = r_digit;
        bun        = '0;

        if (r_rejected) begin
            // dropped until the symbol ends
        end else if (!r_pos[2]) begin
            if (i_byte == prefix_char(r_pos[1:0])) begin
                n_pos = r_pos + 3'd1;
            end else begin
                n_rejected = 1'b1;
            end
        end else if (r_pos == POS_CAPITAL) begin
            if (byte_upper) begin
                bun   = append(bun, i_byte);
                n_pos = POS_BODY;
            end else begin
                n_rejected = 1'b1;
            end
        end else begin
            n_kind = KIND_NONE;
            unique case (r_kind)
                KIND_NONE: begin
                    n_kind = fresh_kind;
                    if (fresh_kind == KIND_NONE) bun = append(bun, i_byte);
                end
                KIND_UNDER: begin
                    if (i_byte == CH_UNDERSCORE) begin
                        bun = append(bun, CH_DOT);
                    end else begin
                        bun    = append(bun, CH_UNDERSCORE);
                        n_kind = fresh_kind;
                        if (fresh_kind == KIND_NONE) bun = append(bun, i_byte);
                    end
                end
                KIND_DOLLAR: begin
                    if (byte_hex) begin
                        n_kind  = KIND_DIGIT;
                        n_digit = i_byte;
                    end else begin
                        bun    = append(bun, CH_DOLLAR);
                        n_kind = fresh_kind;
                        if (fresh_kind == KIND_NONE) bun = append(bun, i_byte);
                    end
                end
                KIND_DIGIT: begin
                    if (byte_hex) begin
                        bun = append(bun, {hex_val(r_digit), hex_val(i_byte)});
                    end else begin
                        bun    = append(bun, CH_DOLLAR);
                        bun    = append(bun, r_digit);
                        n_kind = fresh_kind;
                        if (fresh_kind == KIND_NONE) bun = append(bun, i_byte);
                    end
                    n_digit = '0;
                end
            endcase
        end

        // end of symbol: either one not-flat result or flush what is held
        if (i_last) begin
            if (n_rejected || n_pos != POS_BODY) begin
                bun          = '0;
                bun.count    = 2'd1;
                bun.not_flat = 1'b1;
            end else begin
                unique case (n_kind)
                    KIND_NONE:   ;
                    KIND_UNDER:  bun = append(bun, CH_UNDERSCORE);
                    KIND_DOLLAR: bun = append(bun, CH_DOLLAR);
                    KIND_DIGIT: begin
                        bun = append(bun, CH_DOLLAR);
                        bun = append(bun, n_digit);
                    end
                endcase
            end
            bun.last   = 1'b1;
            n_pos      = '0;
            n_rejected = 1'b0;
            n_kind     = KIND_NONE;
            n_digit    = '0;
        end
    end

    assign o_push   = i_accept && (bun.count != 2'd0);
    assign o_bundle = bun;

    // symbol state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_rejected <= 1'b0;
            r_kind     <= KIND_NONE;
            r_digit    <= '0;
        end else if (i_accept) begin
            r_pos      <= n_pos;
            r_rejected <= n_rejected;
            r_kind     <= n_kind;
            r_digit    <= n_digit;
        end
    end

    // a symbol's last beat leaves the front ready for a new prefix
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |=> (r_pos == '0 && !r_rejected && r_kind == KIND_NONE))
        else $error("front state not cleared after end of symbol");

    // lookahead bytes are only held while decoding the body
    a_kind_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_kind != KIND_NONE) |-> (r_pos == POS_BODY && !r_rejected))
        else $error("lookahead held outside the body");

endmodule

// File: rtl/fsd_queue.sv
`timescale 1ns / 1ps

module fsd_queue
    import fsd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_valid,
    output t_bundle o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_bundle       r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");

endmodule

// File: rtl/fsd_back.sv
`timescale 1ns / 1ps

module fsd_back
    import fsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_bundle    i_head,
    output logic       o_pop,
    output logic       o_m_valid,
    input  logic       i_m_ready,
    output logic [7:0] o_byte,
    output logic       o_not_flat,
    output logic       o_item_done,
    output logic       o_symbol_done
);

    logic [1:0] r_idx;
    logic       r_m_valid;
    logic [7:0] r_byte;
    logic       r_not_flat;
    logic       r_item_done;
    logic       r_symbol_done;

    logic       load;
    logic       slot_last;

    // one result byte per cycle whenever the output register frees up
    assign load      = i_valid && (!r_m_valid || i_m_ready);
    assign slot_last = (r_idx == i_head.count - 2'd1);
    assign o_pop     = load && slot_last;

    // slot counter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx     <= slot_last ? 2'd0 : r_idx + 2'd1;
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte        <= i_head.bytes[r_idx];
            r_not_flat    <= i_head.not_flat;
            r_item_done   <= slot_last;
            r_symbol_done <= slot_last && i_head.last;
        end
    end

    assign o_m_valid     = r_m_valid;
    assign o_byte        = r_byte;
    assign o_not_flat    = r_not_flat;
    assign o_item_done   = r_item_done;
    assign o_symbol_done = r_symbol_done;

    a_idx_in_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (r_idx < i_head.count))
        else $error("slot index beyond the entry's byte count");

endmodule

// File: rtl/flat_symbol_demangler.sv
`timescale 1ns / 1ps

// Flat symbol demangler: takes one symbol byte per beat (tlast on the final
// byte) and emits the demangled bytes, one per beat. A symbol must open with
// "caml" and a capital letter; the four prefix bytes are dropped, "__" gives
// ".", "$" with two hex digits gives that byte, and anything held for
// lookahead is flushed on a failed match or at the end of the symbol. A
// symbol without the prefix gives a single beat with tuser set, a zero byte
// and item_done set. Input is taken at one byte per cycle while the entry
// queue between the classifier and the serializer (QUEUE_DEPTH entries) has
// room; tready drops only when that queue is full, which takes a stalled
// output side. Each byte yields zero to three output beats and the back end
// drives one beat per cycle while tready is high; output never outgrows
// input, so with tready high one byte per cycle is sustained. A byte's first
// beat is registered in the entry queue and then in the output register.

module flat_symbol_demangler
    import fsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = fsd_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input symbol bytes
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] sym_byte
    input  logic        i_s_tlast,   // end_of_symbol
    // demangled bytes
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] out_byte, [8] item_done, [15:9] zero
    output logic        o_m_tuser,   // [0] not_flat
    output logic        o_m_tlast    // symbol_done
);

    logic    accept;
    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_valid;
    t_bundle push_bundle;
    t_bundle head;
    logic [7:0] out_byte;
    logic       item_done;

    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && !q_full;

    fsd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_push   (push),
        .o_bundle (push_bundle)
    );

    fsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .i_pop    (pop),
        .o_full   (q_full),
        .o_valid  (q_valid),
        .o_head   (head)
    );

    fsd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_head        (head),
        .o_pop         (pop),
        .o_m_valid     (o_m_tvalid),
        .i_m_ready     (i_m_tready),
        .o_byte        (out_byte),
        .o_not_flat    (o_m_tuser),
        .o_item_done   (item_done),
        .o_symbol_done (o_m_tlast)
    );

    // pack output beat
    assign o_m_tdata = {7'd0, item_done, out_byte};

endmodule

// File: test/demangle_checker.sv
`timescale 1ns / 1ps

module demangle_checker
    import fsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // symbol byte channel
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] sym_byte
    input  logic        i_s_tlast,   // end_of_symbol
    // demangled byte channel
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [7:0] out_byte, [8] item_done, [15:9] zero
    input  logic        i_m_tuser,   // [0] not_flat
    input  logic        i_m_tlast,   // symbol_done
    output int          o_errors,
    output int          o_pending,
    output int          o_beats
);

    // "caml", first character in the low byte
    localparam logic [31:0] LEAD_TEXT = 32'h6C6D6163;

    typedef struct packed {
        logic [7:0] value;
        logic       not_flat;
        logic       item_done;
        logic       symbol_done;
    } t_demangled_beat;

    // predictor state
    logic [2:0]      prefix_pos;
    logic            rejected;
    t_kind           held;
    logic [7:0]      held_digit;
    logic [7:0]      step_bytes[$];
    t_demangled_beat demangled_q[$];

    function automatic logic is_hex_digit(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c <= 8'h39)
            return c[3:0];
        return c[3:0] + 4'd9;
    endfunction

    task automatic clear_symbol_state();
        prefix_pos = '0;
        rejected   = 1'b0;
        held       = KIND_NONE;
        held_digit = '0;
    endtask

    // byte with nothing held: start a lookahead or pass it on
    task automatic take_plain(input logic [7:0] b);
        if (b == CH_UNDERSCORE)
            held = KIND_UNDER;
        else if (b == CH_DOLLAR)
            held = KIND_DOLLAR;
        else
            step_bytes.push_back(b);
    endtask

    // body decoding with lookahead on "__" and "$hh"
    task automatic decode_body(input logic [7:0] b);
        t_kind k;
        k = held;
        held = KIND_NONE;
        case (k)
            KIND_UNDER: begin
                if (b == CH_UNDERSCORE) begin
                    step_bytes.push_back(CH_DOT);
                end else begin
                    step_bytes.push_back(CH_UNDERSCORE);
                    take_plain(b);
                end
            end
            KIND_DOLLAR: begin
                if (is_hex_digit(b)) begin
                    held = KIND_DIGIT;
                    held_digit = b;
                end else begin
                    step_bytes.push_back(CH_DOLLAR);
                    take_plain(b);
                end
            end
            KIND_DIGIT: begin
                if (is_hex_digit(b)) begin
                    step_bytes.push_back({nibble_of(held_digit), nibble_of(b)});
                end else begin
                    step_bytes.push_back(CH_DOLLAR);
                    step_bytes.push_back(held_digit);
                    take_plain(b);
                end
                held_digit = '0;
            end
            default: take_plain(b);
        endcase
    endtask

    // work out the beats that one symbol byte causes
    task automatic demangle_step(input logic [7:0] b, input logic last);
        t_demangled_beat beat;
        int n;
        step_bytes.delete();
        if (rejected) begin
            // dropped until the end of the symbol
        end else if (prefix_pos < POS_CAPITAL) begin
            if (b == LEAD_TEXT[prefix_pos[1:0] * 8 +: 8])
                prefix_pos = prefix_pos + 3'd1;
            else
                rejected = 1'b1;
        end else if (prefix_pos == POS_CAPITAL) begin
            if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
                step_bytes.push_back(b);
                prefix_pos = POS_BODY;
            end else begin
                rejected = 1'b1;
            end
        end else begin
            decode_body(b);
        end

        // not a flat symbol: a single marker beat
        if (last && (rejected || prefix_pos <= POS_CAPITAL)) begin
            beat = '{value: 8'h00, not_flat: 1'b1, item_done: 1'b1, symbol_done: 1'b1};
            demangled_q.push_back(beat);
            clear_symbol_state();
            return;
        end

        // end of symbol flushes whatever is held
        if (last) begin
            case (held)
                KIND_UNDER:  step_bytes.push_back(CH_UNDERSCORE);
                KIND_DOLLAR: step_bytes.push_back(CH_DOLLAR);
                KIND_DIGIT: begin
                    step_bytes.push_back(CH_DOLLAR);
                    step_bytes.push_back(held_digit);
                end
                default: ;
            endcase
        end

        n = step_bytes.size();
        for (int i = 0; i < n; i++) begin
            beat.value       = step_bytes[i];
            beat.not_flat    = 1'b0;
            beat.item_done   = (i == n - 1);
            beat.symbol_done = last && (i == n - 1);
            demangled_q.push_back(beat);
        end
        if (last)
            clear_symbol_state();
    endtask

    // compare one output beat with the oldest prediction
    task automatic check_beat();
        t_demangled_beat got;
        t_demangled_beat want;
        got = '{value: i_m_tdata[7:0], not_flat: i_m_tuser,
                item_done: i_m_tdata[8], symbol_done: i_m_tlast};
        o_beats++;
        if (demangled_q.size() == 0) begin
            $display("%0t: unexpected beat, actual byte=%02h not_flat=%0b item=%0b sym=%0b",
                     $time, got.value, got.not_flat, got.item_done, got.symbol_done);
            o_errors++;
            return;
        end
        want = demangled_q.pop_front();
        if (got !== want) begin
            $display("%0t: mismatch, expected byte=%02h not_flat=%0b item=%0b sym=%0b",
                     $time, want.value, want.not_flat, want.item_done, want.symbol_done);
            $display("%0t:           actual   byte=%02h not_flat=%0b item=%0b sym=%0b",
                     $time, got.value, got.not_flat, got.item_done, got.symbol_done);
            o_errors++;
        end
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_beats   = 0;
        clear_symbol_state();
    end

    // watch both channels at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_symbol_state();
            demangled_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                demangle_step(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready)
                check_beat();
        end
        o_pending = demangled_q.size();
    end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import fsd_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int RANDOM_BYTES = 280;
    localparam int DRAIN_CYCLES = 20;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;   // [7:0] sym_byte
    logic        i_s_tlast;   // end_of_symbol
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // [7:0] out_byte, [8] item_done, [15:9] zero
    logic        o_m_tuser;   // [0] not_flat
    logic        o_m_tlast;   // symbol_done

    int errors;
    int pending;
    int beats_checked;

    logic [7:0] symbol_bytes[$];
    int         bytes_sent;
    int         symbols_sent;
    bit         sender_steady;
    bit         drained;
    int         idle_cycles;
    int         rcv_cycle;
    int         rcv_stall;
    bit         rcv_steady;
    int         rcv_roll;

    flat_symbol_demangler i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    demangle_checker i_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .i_m_tuser  (o_m_tuser),
        .i_m_tlast  (o_m_tlast),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_beats    (beats_checked)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // end the run when neither channel moves for too long
    initial idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver back-pressure: short stalls, rare long ones, some stall-free stretches
    initial begin
        i_m_tready = 1'b0;
        rcv_cycle  = 0;
        rcv_stall  = 0;
        rcv_steady = 1'b0;
    end
    always @(negedge i_clk) begin
        if (rcv_cycle % 64 == 0)
            rcv_steady = ($urandom_range(0, 3) == 0);
        rcv_cycle++;
        if (rcv_steady) begin
            i_m_tready = 1'b1;
        end else if (rcv_stall > 0) begin
            i_m_tready = 1'b0;
            rcv_stall--;
        end else begin
            rcv_roll = $urandom_range(0, 99);
            if (rcv_roll < 70) begin
                i_m_tready = 1'b1;
            end else begin
                i_m_tready = 1'b0;
                rcv_stall = (rcv_roll < 97) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // drive one symbol byte and hold it until taken
    task automatic send_beat(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = b;
        i_s_tlast  = last;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_symbol();
        sender_steady = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < symbol_bytes.size(); i++)
            send_beat(symbol_bytes[i], i == symbol_bytes.size() - 1);
        symbols_sent++;
    endtask

    task automatic load_text(input string s);
        symbol_bytes.delete();
        for (int i = 0; i < s.len(); i++)
            symbol_bytes.push_back(s[i]);
    endtask

    // body byte biased toward the escape characters and hex digits
    function automatic logic [7:0] pick_body_byte();
        string hex_chars;
        int r;
        hex_chars = "0123456789abcdefABCDEF";
        r = $urandom_range(0, 99);
        if (r < 20)
            return CH_UNDERSCORE;
        if (r < 40)
            return CH_DOLLAR;
        if (r < 70)
            return hex_chars[$urandom_range(0, hex_chars.len() - 1)];
        return 8'($urandom_range(1, 255));
    endfunction

    // mostly well-formed symbols, some broken prefixes, some noise
    task automatic build_random_symbol();
        int r;
        int cut;
        int len;
        r = $urandom_range(0, 99);
        load_text("caml");
        symbol_bytes.push_back(8'($urandom_range(CH_UPPER_A, CH_UPPER_Z)));
        if (r < 75) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 8);
            repeat (len) symbol_bytes.push_back(pick_body_byte());
        end else if (r < 90) begin
            // truncated or corrupted prefix, possibly with a tail
            cut = $urandom_range(1, 5);
            while (symbol_bytes.size() > cut)
                void'(symbol_bytes.pop_back());
            if ($urandom_range(0, 2) != 0)
                symbol_bytes[$urandom_range(0, cut - 1)] = 8'($urandom_range(1, 255));
            repeat ($urandom_range(0, 4)) symbol_bytes.push_back(pick_body_byte());
        end else begin
            symbol_bytes.delete();
            repeat ($urandom_range(1, 6)) symbol_bytes.push_back(8'($urandom_range(1, 255)));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tlast     = 1'b0;
        bytes_sent    = 0;
        symbols_sent  = 0;
        sender_steady = 1'b0;
        drained       = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: end inside the prefix, dot, zero value, flushes, byte extremes
        load_text("caml");
        send_symbol();
        load_text("camlZ__$00_a$7");
        send_symbol();
        symbol_bytes = {8'h01, 8'hFF};
        send_symbol();
        load_text("camlA$$0_");
        send_symbol();

        // random symbols, with one full drain halfway through
        while (bytes_sent < RANDOM_BYTES) begin
            if (!drained && bytes_sent >= RANDOM_BYTES / 2) begin
                i_s_tvalid = 1'b0;
                while (pending != 0)
                    @(negedge i_clk);
                drained = 1'b1;
            end
            build_random_symbol();
            send_symbol();
        end
        i_s_tvalid = 1'b0;

        // let the output side drain
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("drove %0d symbol bytes in %0d symbols, checked %0d demangled beats",
                 bytes_sent, symbols_sent, beats_checked);
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/fsd_pkg.sv
rtl/fsd_front.sv
rtl/fsd_queue.sv
rtl/fsd_back.sv
rtl/flat_symbol_demangler.sv
test/demangle_checker.sv
test/tb.sv
